/* rtl/acl_pkg.sv */
// Shared constants, codes and types of the amplification classifier.
package acl_pkg;

   localparam int NUM_SLOTS  = 256;
   localparam int ADDR_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_W     = 8;
   localparam int LEN_W      = 16;
   localparam int TOTAL_W    = 48;
   localparam int COUNT_W    = 32;
   localparam int RATIO_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int LIMIT_W    = 48;
   localparam int SCORE_W    = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;
   localparam int DIV_STEPS  = RATIO_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [COUNT_W-1:0] RESPONSE_FLOOR_RST   = COUNT_W'(100);
   localparam logic [RATIO_W-1:0] RATIO_FLOOR_RST      = RATIO_W'(327680);
   localparam logic [LIMIT_W-1:0] MALICIOUS_LIMIT_RST  = LIMIT_W'(65536000);
   localparam logic [LIMIT_W-1:0] SUSPICIOUS_LIMIT_RST = LIMIT_W'(6553600);

   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_FLOOR   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_FLOOR      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MALICIOUS_LIMIT  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SUSPICIOUS_LIMIT = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      ACT_SEND  = 2'd0,
      ACT_RECV  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_QUERY = 2'd3
   } acl_action_type;

   typedef enum logic [1:0] {
      CLASS_NORMAL     = 2'd0,
      CLASS_SUSPICIOUS = 2'd1,
      CLASS_MALICIOUS  = 2'd2
   } acl_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SCORE,
      ST_DONE
   } acl_state_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] sent;
      logic [TOTAL_W-1:0] recv;
      logic [COUNT_W-1:0] resp;
      logic [COUNT_W-1:0] req;
      acl_class_type      cls;
   } acl_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              clr_en;
      logic [ADDR_W-1:0] addr;
   } acl_tbl_cmd_type;

endpackage

/* rtl/acl_if.sv */
// Request, response and register-write channel interfaces.
interface acl_req_if import acl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0]  msg_len;

   modport source (output valid, output action, output slot, output msg_len, input ready);
   modport sink (input valid, input action, input slot, input msg_len, output ready);
endinterface

interface acl_rsp_if import acl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot_out;
   logic [1:0]         traffic_class;
   logic [RATIO_W-1:0] ratio_out;

   modport source (output valid, output slot_out, output traffic_class, output ratio_out,
                   input ready);
   modport sink (input valid, input slot_out, input traffic_class, input ratio_out,
                 output ready);
endinterface

interface acl_csr_if import acl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/acl_table.sv */
// Connection table: single-port memory with per-slot valid bits.
module acl_table import acl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  acl_tbl_cmd_type cmd,
   input  acl_entry_type   wr_entry,
   output acl_entry_type   rd_entry
);

   acl_entry_type         mem_ff [NUM_SLOTS];
   acl_entry_type         rd_ff;
   logic                  rd_valid_ff;
   logic [NUM_SLOTS-1:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.addr] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.addr];
         end
         if (cmd.wr_en) begin
            valid_ff[cmd.addr] <= 1'b1;
         end else if (cmd.clr_en) begin
            valid_ff[cmd.addr] <= 1'b0;
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_ff : '0;

endmodule

/* rtl/acl_div.sv */
// Restoring bit-serial divider forming the saturated Q16.16 send/receive ratio.
module acl_div import acl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] sent,
   input  logic [TOTAL_W-1:0] recv,
   output logic               done,
   output logic [RATIO_W-1:0] quot
);

   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [RATIO_W-1:0]   low_ff, low_in;
   logic [RATIO_W-1:0]   quot_ff, quot_in;
   logic [TOTAL_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [TOTAL_W:0]     trial;
   logic                 fits;
   logic                 saturate;

   assign saturate = {16'b0, sent} >= {recv, 16'b0};
   assign trial    = {rem_ff, low_ff[RATIO_W-1]};
   assign fits     = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (start) begin
         divisor_in = recv;
         if (saturate) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = {16'b0, sent[TOTAL_W-1:FRAC_W]};
            low_in  = {sent[FRAC_W-1:0], 16'b0};
            quot_in = '0;
            cnt_in  = DIV_CNT_W'(DIV_STEPS);
            run_in  = 1'b1;
         end
      end else if (run_ff) begin
         rem_in  = fits ? TOTAL_W'(trial - {1'b0, divisor_ff}) : trial[TOTAL_W-1:0];
         low_in  = {low_ff[RATIO_W-2:0], 1'b0};
         quot_in = {quot_ff[RATIO_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/amplification_classifier_core.sv */
// Per-connection amplification classifier: top level with sequencer and registers.
// Each request (send, receive, clear or query on one of NUM_SLOTS connection slots)
// is read from a single-port table and yields exactly one response; a send or receive
// is updated and written back, and a clear invalidates its slot. A request that forms
// a ratio passes through these steps from acceptance to response: accept and read the
// slot, update the totals, the 32-step restoring divider that forms the Q16.16 ratio
// (its steps skipped when the ratio saturates), the ratio check and the 32x32 score
// multiply, the class compare and write back, and load the response register; a ratio
// below the floor skips the class compare. Other requests go from the update straight
// to the response register. The divider sets the rate. One request is in flight at a
// time; the next one is taken while the previous response waits in the output register.
// The table's reset state is held by one valid bit per slot, so no clearing pass
// follows reset. Register writes are always taken.
module amplification_classifier_core import acl_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   acl_req_if.sink   req_bus,
   acl_rsp_if.source rsp_bus,
   acl_csr_if.sink   csr_bus
);

   acl_state_type      state_ff, state_in;

   logic [COUNT_W-1:0] resp_floor_ff;
   logic [RATIO_W-1:0] ratio_floor_ff;
   logic [LIMIT_W-1:0] mal_limit_ff;
   logic [LIMIT_W-1:0] sus_limit_ff;

   acl_action_type     act_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               in_range_ff;
   acl_entry_type      entry_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic [SCORE_W-1:0] score_ff;
   acl_class_type      res_cls_ff;
   logic [RATIO_W-1:0] res_ratio_ff;

   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   acl_class_type      rsp_cls_ff;
   logic [RATIO_W-1:0] rsp_ratio_ff;

   acl_tbl_cmd_type    tbl_cmd;
   acl_entry_type      tbl_wr_entry;
   acl_entry_type      tbl_rd_entry;
   acl_entry_type      upd_entry;
   acl_entry_type      score_entry;

   logic               div_start;
   logic               div_done;
   logic [RATIO_W-1:0] div_quot;

   logic               accept;
   logic               load_rsp;
   logic               is_traffic;
   logic               classify;
   acl_class_type      keep_cls;
   acl_class_type      want_cls;
   acl_class_type      new_cls;
   logic [TOTAL_W:0]   sent_sum;
   logic [TOTAL_W:0]   recv_sum;
   logic [COUNT_W-1:0] cnt_excess;
   logic [RATIO_W-1:0] ratio_excess;
   logic [SCORE_W-1:0] score_in;

   acl_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .wr_entry (tbl_wr_entry),
      .rd_entry (tbl_rd_entry)
   );

   acl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sent  (upd_entry.sent),
      .recv  (upd_entry.recv),
      .done  (div_done),
      .quot  (div_quot)
   );

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_floor_ff  <= RESPONSE_FLOOR_RST;
         ratio_floor_ff <= RATIO_FLOOR_RST;
         mal_limit_ff   <= MALICIOUS_LIMIT_RST;
         sus_limit_ff   <= SUSPICIOUS_LIMIT_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RESPONSE_FLOOR:   resp_floor_ff  <= csr_bus.data[COUNT_W-1:0];
            CSR_RATIO_FLOOR:      ratio_floor_ff <= csr_bus.data[RATIO_W-1:0];
            CSR_MALICIOUS_LIMIT:  mal_limit_ff   <= csr_bus.data[LIMIT_W-1:0];
            CSR_SUSPICIOUS_LIMIT: sus_limit_ff   <= csr_bus.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // slot update
   always_comb begin
      upd_entry = tbl_rd_entry;
      sent_sum  = {1'b0, tbl_rd_entry.sent} + (TOTAL_W + 1)'(len_ff);
      recv_sum  = {1'b0, tbl_rd_entry.recv} + (TOTAL_W + 1)'(len_ff);
      case (act_ff)
         ACT_SEND: begin
            upd_entry.sent = sent_sum[TOTAL_W] ? '1 : sent_sum[TOTAL_W-1:0];
            upd_entry.resp = (&tbl_rd_entry.resp) ? tbl_rd_entry.resp
                                                  : tbl_rd_entry.resp + 1'b1;
         end
         ACT_RECV: begin
            upd_entry.recv = recv_sum[TOTAL_W] ? '1 : recv_sum[TOTAL_W-1:0];
            upd_entry.req  = (&tbl_rd_entry.req) ? tbl_rd_entry.req
                                                 : tbl_rd_entry.req + 1'b1;
         end
         default: ;
      endcase
   end

   assign is_traffic = in_range_ff && (act_ff == ACT_SEND || act_ff == ACT_RECV);
   assign classify   = is_traffic && (upd_entry.resp >= resp_floor_ff)
                       && (upd_entry.sent != '0 || upd_entry.recv != '0);
   assign keep_cls   = (in_range_ff && act_ff != ACT_CLEAR) ? tbl_rd_entry.cls
                                                            : CLASS_NORMAL;

   // score and class
   assign cnt_excess   = entry_ff.resp - resp_floor_ff;
   assign ratio_excess = ratio_ff - ratio_floor_ff;
   assign score_in     = {32'b0, cnt_excess} * {32'b0, ratio_excess};

   always_comb begin
      if (score_ff >= SCORE_W'(mal_limit_ff)) begin
         want_cls = CLASS_MALICIOUS;
      end else if (score_ff >= SCORE_W'(sus_limit_ff)) begin
         want_cls = CLASS_SUSPICIOUS;
      end else begin
         want_cls = CLASS_NORMAL;
      end
      new_cls = (want_cls > entry_ff.cls) ? want_cls : entry_ff.cls;
      score_entry     = entry_ff;
      score_entry.cls = new_cls;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = classify ? ST_DIVIDE : ST_DONE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = (ratio_ff >= ratio_floor_ff) ? ST_SCORE : ST_DONE;
         ST_SCORE: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready  = 1'b0;
      div_start      = 1'b0;
      load_rsp       = 1'b0;
      tbl_cmd.rd_en  = 1'b0;
      tbl_cmd.wr_en  = 1'b0;
      tbl_cmd.clr_en = 1'b0;
      tbl_cmd.addr   = ADDR_W'(slot_ff);
      tbl_wr_entry   = upd_entry;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            tbl_cmd.rd_en = req_bus.valid;
            tbl_cmd.addr  = ADDR_W'(req_bus.slot);
         end
         ST_UPDATE: begin
            tbl_cmd.wr_en  = is_traffic;
            tbl_cmd.clr_en = in_range_ff && act_ff == ACT_CLEAR;
            div_start      = classify;
         end
         ST_SCORE: begin
            tbl_cmd.wr_en = 1'b1;
            tbl_wr_entry  = score_entry;
         end
         ST_DONE: load_rsp = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= acl_action_type'(req_bus.action);
         slot_ff     <= req_bus.slot;
         len_ff      <= req_bus.msg_len;
         in_range_ff <= (17)'(req_bus.slot) < (17)'(NUM_SLOTS);
      end
      case (state_ff)
         ST_UPDATE: begin
            entry_ff     <= upd_entry;
            res_cls_ff   <= keep_cls;
            res_ratio_ff <= '0;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ratio_ff     <= div_quot;
               res_ratio_ff <= div_quot;
            end
         end
         ST_CHECK: score_ff <= score_in;
         ST_SCORE: res_cls_ff <= new_cls;
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_slot_ff  <= slot_ff;
         rsp_cls_ff   <= res_cls_ff;
         rsp_ratio_ff <= res_ratio_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.slot_out      = rsp_slot_ff;
   assign rsp_bus.traffic_class = rsp_cls_ff;
   assign rsp_bus.ratio_out     = rsp_ratio_ff;

endmodule
